// ===== rtl/dte_pkg.sv =====
// ============================================================================
// dte_pkg
// Shared types, codes and helpers for the decision tree evaluator.
// ============================================================================
package dte_pkg;

    // Default table depth and the clamp on the configured input width
    localparam int MAX_NODES_DEFAULT = 256;
    localparam int MAX_INPUT_BITS    = 32;

    localparam logic [5:0] CFG_WIDTH_RESET = 6'd32;

    // Item kind, carried on the input tuser
    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_WIDTH_ERR  = 2'd1,
        STATUS_STEP_LIMIT = 2'd2
    } status_t;

    // Stored node word, 23 bits
    typedef struct packed {
        logic       is_leaf;
        logic       leaf_value;
        logic [4:0] split_bit;
        logic [7:0] one_child;
        logic [7:0] zero_child;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Input tdata, lowest field in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [31:0] input_bits;
        logic [7:0]  one_child;
        logic [7:0]  zero_child;
        logic [4:0]  split_bit;
        logic        leaf_value;
        logic        node_is_leaf;
        logic [7:0]  node_index;
    } in_data_t;

    typedef struct packed {
        logic [4:0] pad;
        status_t    status;
        logic       tree_value;
    } out_data_t;

    // Controller to datapath
    typedef struct packed {
        logic write_node;
        logic walk_start;
        logic walking;
        logic capture;
        logic load_out;
    } dte_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } dte_sts_t;

    // Reduce an 8-bit index into [0, nodes): eight conditional subtracts
    function automatic logic [7:0] slot_of(logic [7:0] idx, int nodes);
        int v;
        v = int'(idx);
        for (int k = 7; k >= 0; k--) begin
            if (v >= (nodes << k)) begin
                v = v - (nodes << k);
            end
        end
        return 8'(v);
    endfunction

endpackage

// ===== rtl/dte_ram.sv =====
// ============================================================================
// dte_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module dte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/dte_ctrl.sv =====
// ============================================================================
// dte_ctrl
// Sequencer: takes items, runs the tree walk and hands the result on.
// ============================================================================
module dte_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_action,
    output logic              s_ready,
    input  dte_pkg::dte_sts_t sts,
    output dte_pkg::dte_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.write_node = accept && (s_action == dte_pkg::ACTION_WRITE);
        cmd.walk_start = accept && (s_action == dte_pkg::ACTION_EVAL);
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.walk_start) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.walking = 1'b1;
                if (sts.walk_done) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/dte_datapath.sv =====
// ============================================================================
// dte_datapath
// Node table, walk registers, width register and output register.
// ============================================================================
module dte_datapath #(
    parameter int MAX_NODES = dte_pkg::MAX_NODES_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [5:0]        cfg_wdata,
    input  logic [63:0]       s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    input  dte_pkg::dte_cmd_t cmd,
    output dte_pkg::dte_sts_t sts
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int SW = $clog2(MAX_NODES);
    localparam logic [SW-1:0] STEP_LAST = SW'(MAX_NODES - 1);

    dte_pkg::in_data_t  in_data;
    dte_pkg::node_t     node;
    dte_pkg::node_t     wr_node;
    dte_pkg::out_data_t out_data;

    logic [dte_pkg::NODE_W-1:0] rd_data;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              next_slot;
    logic [7:0]                 child;
    logic                       bit_in_range;
    logic                       walk_done;

    logic [5:0]             width_reg;
    logic [31:0]            bits_reg;
    logic [SW-1:0]          steps_reg, steps_next;
    logic                   res_value_reg, walk_value;
    dte_pkg::status_t       res_status_reg, walk_status;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_value_reg;
    dte_pkg::status_t       out_status_reg;

    assign in_data = dte_pkg::in_data_t'(s_tdata);

    assign wr_node.is_leaf    = in_data.node_is_leaf;
    assign wr_node.leaf_value = in_data.leaf_value;
    assign wr_node.split_bit  = in_data.split_bit;
    assign wr_node.one_child  = in_data.one_child;
    assign wr_node.zero_child = in_data.zero_child;
    assign wr_addr = AW'(dte_pkg::slot_of(in_data.node_index, MAX_NODES));

    // Root is read while idle, so node 0 is out the cycle after the start
    assign rd_addr = cmd.walking ? next_slot : '0;

    dte_ram #(
        .WIDTH (dte_pkg::NODE_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (cmd.write_node),
        .wr_addr (wr_addr),
        .wr_data (wr_node),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign node  = dte_pkg::node_t'(rd_data);
    assign child = bits_reg[node.split_bit] ? node.one_child : node.zero_child;
    assign next_slot = AW'(dte_pkg::slot_of(child, MAX_NODES));

    assign bit_in_range = ({1'b0, node.split_bit} < width_reg)
                       && ({2'b00, node.split_bit} < 7'(dte_pkg::MAX_INPUT_BITS));

    always_comb begin
        walk_done   = 1'b1;
        walk_value  = 1'b0;
        walk_status = dte_pkg::STATUS_OK;
        if (node.is_leaf) begin
            walk_value = node.leaf_value;
        end else if (!bit_in_range) begin
            walk_status = dte_pkg::STATUS_WIDTH_ERR;
        end else if (steps_reg == STEP_LAST) begin
            walk_status = dte_pkg::STATUS_STEP_LIMIT;
        end else begin
            walk_done = 1'b0;
        end
    end

    assign sts.walk_done = walk_done;
    assign sts.out_free  = !out_valid_reg || m_tready;

    always_comb begin
        steps_next = steps_reg;
        if (cmd.walk_start) begin
            steps_next = '0;
        end else if (cmd.walking) begin
            steps_next = steps_reg + SW'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= dte_pkg::CFG_WIDTH_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                width_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        steps_reg <= steps_next;
        if (cmd.walk_start) begin
            bits_reg <= in_data.input_bits;
        end
        if (cmd.capture) begin
            res_value_reg  <= walk_value;
            res_status_reg <= walk_status;
        end
        if (cmd.load_out) begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_data.pad        = '0;
    assign out_data.status     = out_status_reg;
    assign out_data.tree_value = out_value_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data;

endmodule

// ===== rtl/decision_tree_evaluator_top.sv =====
// ============================================================================
// decision_tree_evaluator_top
// Binary decision tree evaluator with a node table and a stream interface.
// ============================================================================
// A write item (tuser 0) stores one node. An evaluate item (tuser 1)
// walks from node 0 reading one node per cycle from the node table RAM,
// at most MAX_NODES nodes read; when the walk ends its result is
// captured, then loaded into the output register once that is free, and
// the next item is taken after the load. One result per evaluate item. A
// result held downstream does not stop the next item being taken, but
// once that next walk has finished its result waits and the input stalls
// until the held result is transferred. Nodes must be written before a
// walk reaches them. Status 1 flags a split bit at or beyond the
// configured width, status 2 a walk that ran out of steps.
module decision_tree_evaluator_top #(
    parameter int MAX_NODES = dte_pkg::MAX_NODES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [5:0]  cfg_wdata,     // input_width
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // node_index, node_is_leaf, leaf_value, split_bit, zero_child,
    // one_child, input_bits, pad
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // tree_value, status, pad
);

    dte_pkg::dte_cmd_t cmd;
    dte_pkg::dte_sts_t sts;

    dte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_action (s_axis_tuser),
        .s_ready  (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dte_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_axis_tdata),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.write_node, cmd.walk_start, cmd.walking, cmd.load_out}))
        else $error("controller commands overlap");

    a_start_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_start |=> cmd.walking && !s_axis_tready)
        else $error("walk did not start after evaluate transfer");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an unread result");

    a_capture_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !cmd.walking && !s_axis_tready)
        else $error("result loaded outside the done state");

endmodule
